// ===== design/cts_pkg.sv =====
// Shared constants, character classes and defaults for the C-like token scanner.
package cts_pkg;

	localparam int LEN_BITS_DEF = 12;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;

	localparam logic [2:0] T_INT     = 3'd0;
	localparam logic [2:0] T_FLOAT   = 3'd1;
	localparam logic [2:0] T_IDENT   = 3'd2;
	localparam logic [2:0] T_STRING  = 3'd3;
	localparam logic [2:0] T_SINGLE  = 3'd4;
	localparam logic [2:0] T_COMMENT = 3'd5;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

endpackage

// ===== design/cts_if.sv =====
// Request channel interfaces: character input and token output.
interface cts_char_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] char_code;

	modport source (output valid, output action, output char_code, input ready);
	modport sink   (input valid, input action, input char_code, output ready);
endinterface

interface cts_tok_if #(
	parameter int LENGTH_BITS = cts_pkg::LEN_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [2:0]             token_type;
	logic [LENGTH_BITS-1:0] token_length;
	logic [7:0]             first_char;
	logic                   comment_open;
	logic                   error_code;
	logic                   last;

	modport source (output valid, output token_type, output token_length, output first_char,
		output comment_open, output error_code, output last, input ready);
	modport sink   (input valid, input token_type, input token_length, input first_char,
		input comment_open, input error_code, input last, output ready);
endinterface

// ===== design/c_like_token_scanner.sv =====
// C-like token scanner: scan state machine feeding a four-entry token queue.
// Up to two tokens per request are written to the queue on acceptance and offered on tok.
// Throughput: one character request per cycle while chr.ready is high; tokens drain at
// one per cycle while tok.ready is high; chr.ready drops with fewer than two slots free.
// Reset (arst_n low, asynchronous) returns the scanner to idle and empties the queue.
module c_like_token_scanner #(
	parameter int LENGTH_BITS = cts_pkg::LEN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	cts_char_if.sink    chr,
	cts_tok_if.source   tok
);
	import cts_pkg::*;

	localparam logic [3:0] M_IDLE  = 4'd0;
	localparam logic [3:0] M_INT   = 4'd1;
	localparam logic [3:0] M_FLOAT = 4'd2;
	localparam logic [3:0] M_IDENT = 4'd3;
	localparam logic [3:0] M_STR   = 4'd4;
	localparam logic [3:0] M_ESC   = 4'd5;
	localparam logic [3:0] M_SLASH = 4'd6;
	localparam logic [3:0] M_LINE  = 4'd7;
	localparam logic [3:0] M_BLOCK = 4'd8;
	localparam logic [3:0] M_BSTAR = 4'd9;
	localparam logic [3:0] M_CONT  = 4'd10;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

	typedef struct packed {
		logic [2:0]             token_type;
		logic [LENGTH_BITS-1:0] token_length;
		logic [7:0]             first_char;
		logic                   comment_open;
		logic                   error_code;
		logic                   last;
	} tok_t;

	logic [3:0]             mode_q, mode_d;
	logic [LENGTH_BITS-1:0] len_q, len_d, len_inc;
	logic [7:0]             start_q, start_d;

	tok_t       tok_a, tok_b, ent0, ent1;
	logic       a_vld, b_vld, restart;
	logic [7:0] c;

	tok_t       queue_q [4];
	logic [1:0] rd_ptr_q, wr_ptr_q;
	logic [2:0] cnt_q;
	logic       accept, pop;
	logic [1:0] push_n;

	assign c       = chr.char_code;
	assign len_inc = (len_q == LEN_MAX) ? len_q : len_q + LEN_ONE;
	assign accept  = chr.valid && chr.ready;
	assign pop     = tok.valid && tok.ready;

	always_comb begin
		mode_d  = mode_q;
		len_d   = len_q;
		start_d = start_q;
		a_vld   = 1'b0;
		b_vld   = 1'b0;
		restart = 1'b0;
		tok_a   = '{T_SINGLE, LEN_ONE, CH_SLASH, 1'b0, 1'b0, 1'b0};
		tok_b   = '{T_SINGLE, LEN_ONE, c, 1'b0, 1'b0, 1'b0};
		if (chr.action) begin
			mode_d  = M_IDLE;
			len_d   = '0;
			start_d = '0;
			case (mode_q)
				M_INT: begin
					a_vld = 1'b1;
					tok_a = '{T_INT, len_q, start_q, 1'b0, 1'b0, 1'b0};
				end
				M_FLOAT: begin
					a_vld = 1'b1;
					tok_a = '{T_FLOAT, len_q, start_q, 1'b0, 1'b0, 1'b0};
				end
				M_IDENT: begin
					a_vld = 1'b1;
					tok_a = '{T_IDENT, len_q, start_q, 1'b0, 1'b0, 1'b0};
				end
				M_STR, M_ESC: begin
					a_vld = 1'b1;
					tok_a = '{T_STRING, len_q, start_q, 1'b0, 1'b1, 1'b0};
				end
				M_SLASH: begin
					a_vld = 1'b1;
				end
				M_LINE: begin
					a_vld = 1'b1;
					tok_a = '{T_COMMENT, len_q, start_q, 1'b0, 1'b0, 1'b0};
				end
				M_BLOCK, M_BSTAR: begin
					a_vld  = 1'b1;
					tok_a  = '{T_COMMENT, len_q, start_q, 1'b1, 1'b0, 1'b0};
					mode_d = M_CONT;
				end
				M_CONT: begin
					mode_d = M_CONT;
				end
				default: begin
					mode_d = M_IDLE;
				end
			endcase
		end else begin
			case (mode_q)
				M_INT, M_FLOAT: begin
					if (is_digit(c) || c == CH_DOT) begin
						if (c == CH_DOT)
							mode_d = M_FLOAT;
						len_d = len_inc;
					end else begin
						a_vld   = 1'b1;
						tok_a   = '{(mode_q == M_FLOAT) ? T_FLOAT : T_INT, len_q, start_q,
							1'b0, 1'b0, 1'b0};
						restart = 1'b1;
					end
				end
				M_IDENT: begin
					if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
						len_d = len_inc;
					end else begin
						a_vld   = 1'b1;
						tok_a   = '{T_IDENT, len_q, start_q, 1'b0, 1'b0, 1'b0};
						restart = 1'b1;
					end
				end
				M_STR: begin
					len_d = len_inc;
					if (c == CH_BSLASH) begin
						mode_d = M_ESC;
					end else if (c == CH_QUOTE) begin
						a_vld  = 1'b1;
						tok_a  = '{T_STRING, len_inc, start_q, 1'b0, 1'b0, 1'b0};
						mode_d = M_IDLE;
						len_d  = '0;
					end
				end
				M_ESC: begin
					len_d  = len_inc;
					mode_d = M_STR;
				end
				M_SLASH: begin
					if (c == CH_SLASH) begin
						len_d  = len_inc;
						mode_d = M_LINE;
					end else if (c == CH_STAR) begin
						len_d  = len_inc;
						mode_d = M_BLOCK;
					end else begin
						a_vld   = 1'b1;
						restart = 1'b1;
					end
				end
				M_LINE: begin
					len_d = len_inc;
				end
				M_BLOCK: begin
					len_d = len_inc;
					if (c == CH_STAR)
						mode_d = M_BSTAR;
				end
				M_BSTAR: begin
					len_d = len_inc;
					if (c == CH_SLASH) begin
						a_vld  = 1'b1;
						tok_a  = '{T_COMMENT, len_inc, start_q, 1'b0, 1'b0, 1'b0};
						mode_d = M_IDLE;
						len_d  = '0;
					end else if (c != CH_STAR) begin
						mode_d = M_BLOCK;
					end
				end
				M_CONT: begin
					if (!is_blank(c)) begin
						start_d = c;
						len_d   = LEN_ONE;
						mode_d  = (c == CH_STAR) ? M_BSTAR : M_BLOCK;
					end
				end
				default: begin
					restart = 1'b1;
				end
			endcase
			if (restart) begin
				start_d = c;
				len_d   = LEN_ONE;
				if (is_blank(c)) begin
					mode_d  = M_IDLE;
					len_d   = '0;
					start_d = '0;
				end else if (is_digit(c)) begin
					mode_d = M_INT;
				end else if (c == CH_QUOTE) begin
					mode_d = M_STR;
				end else if (c == CH_SLASH) begin
					mode_d = M_SLASH;
				end else if (is_alpha(c) || c == CH_UNDER) begin
					mode_d = M_IDENT;
				end else begin
					b_vld  = 1'b1;
					mode_d = M_IDLE;
					len_d  = '0;
				end
			end
		end
	end

	// last marks the final token of the request
	always_comb begin
		ent0      = a_vld ? tok_a : tok_b;
		ent0.last = !(a_vld && b_vld);
		ent1      = tok_b;
		ent1.last = 1'b1;
		push_n    = accept ? ({1'b0, a_vld} + {1'b0, b_vld}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			len_q    <= '0;
			start_q  <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				mode_q  <= mode_d;
				len_q   <= len_d;
				start_q <= start_d;
			end
			wr_ptr_q <= wr_ptr_q + push_n;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			queue_q[wr_ptr_q] <= ent0;
		if (push_n == 2'd2)
			queue_q[wr_ptr_q + 2'd1] <= ent1;
	end

	assign chr.ready        = cnt_q < 3'd3;
	assign tok.valid        = cnt_q != 3'd0;
	assign tok.token_type   = queue_q[rd_ptr_q].token_type;
	assign tok.token_length = queue_q[rd_ptr_q].token_length;
	assign tok.first_char   = queue_q[rd_ptr_q].first_char;
	assign tok.comment_open = queue_q[rd_ptr_q].comment_open;
	assign tok.error_code   = queue_q[rd_ptr_q].error_code;
	assign tok.last         = queue_q[rd_ptr_q].last;

endmodule
